### src/mcr_pkg.sv
`default_nettype none

package mcr_pkg;

    localparam int RADIUS_BITS_DEF = 10;
    localparam int COORD_BITS_DEF  = 12;
    localparam int OUT_BITS        = 13;
    localparam int IDX_BITS        = 3;

    localparam logic [IDX_BITS-1:0] OUTLINE_LAST_IDX = 3'd7;
    localparam logic [IDX_BITS-1:0] FILL_LAST_IDX    = 3'd3;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic                load_start;
        logic                take_step;
        logic                load_out;
        logic                last;
        logic [IDX_BITS-1:0] idx;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic can_step;
        logic fill;
    } dp_status_t;

endpackage

`default_nettype wire

### src/mcr_ctrl.sv
`default_nettype none

module mcr_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_operation,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire mcr_pkg::dp_status_t status,
    output mcr_pkg::ctrl_cmd_t      cmd
);

    mcr_pkg::state_t                 state_reg, state_next;
    logic [mcr_pkg::IDX_BITS-1:0]    idx_reg, idx_next;
    logic                            m_valid_reg, m_valid_next;
    logic [mcr_pkg::IDX_BITS-1:0]    last_idx;
    logic                            accept;

    assign s_ready  = (state_reg == mcr_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign accept   = s_valid && s_ready;
    assign last_idx = status.fill ? mcr_pkg::FILL_LAST_IDX : mcr_pkg::OUTLINE_LAST_IDX;

    // outputs
    always_comb begin
        cmd.load_start = accept && (mcr_pkg::op_t'(s_operation) == mcr_pkg::OP_START);
        cmd.take_step  = accept && (mcr_pkg::op_t'(s_operation) == mcr_pkg::OP_ADVANCE)
                         && status.can_step;
        cmd.load_out   = (state_reg == mcr_pkg::ST_EMIT) && (!m_valid_reg || m_ready);
        cmd.idx        = idx_reg;
        cmd.last       = (idx_reg == last_idx);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mcr_pkg::ST_IDLE: begin
                if (cmd.take_step) begin
                    state_next = mcr_pkg::ST_EMIT;
                end
            end
            mcr_pkg::ST_EMIT: begin
                if (cmd.load_out && cmd.last) begin
                    state_next = mcr_pkg::ST_IDLE;
                end
            end
            default: state_next = mcr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.take_step) begin
            idx_next = '0;
        end else if (cmd.load_out) begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mcr_pkg::ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

### src/mcr_dp.sv
`default_nettype none

module mcr_dp #(
    parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic        [RADIUS_BITS-1:0]      s_radius,
    input  wire logic signed [COORD_BITS-1:0]       s_center_x,
    input  wire logic signed [COORD_BITS-1:0]       s_center_y,
    input  wire logic                               s_fill_mode,
    input  wire mcr_pkg::ctrl_cmd_t                 cmd,
    output mcr_pkg::dp_status_t                     status,
    output logic signed [mcr_pkg::OUT_BITS-1:0]     m_span_x_left,
    output logic signed [mcr_pkg::OUT_BITS-1:0]     m_span_x_right,
    output logic signed [mcr_pkg::OUT_BITS-1:0]     m_span_row,
    output logic                                    m_last_of_step,
    output logic                                    m_circle_done
);

    localparam int XW = RADIUS_BITS + 1;
    localparam int DW = RADIUS_BITS + 6;
    localparam int SW = ((COORD_BITS > XW) ? COORD_BITS : XW) + 1;
    localparam int WW = (SW > mcr_pkg::OUT_BITS) ? SW : mcr_pkg::OUT_BITS;
    localparam int OW = mcr_pkg::OUT_BITS;

    logic signed [XW-1:0]         x_reg, y_reg, ex_reg, ey_reg;
    logic signed [DW-1:0]         dec_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic                         fill_reg, active_reg, done_reg;

    logic signed [XW-1:0]         x_next, y_next;
    logic signed [DW-1:0]         dec_next, dec_init, r_ext;
    logic                         done_next;

    logic signed [WW-1:0]         cxw, cyw, xw, yw;
    logic signed [WW-1:0]         cx_px, cx_mx, cx_py, cx_my, cy_py, cy_my, cy_px, cy_mx;
    logic signed [OW-1:0]         sel_left, sel_right, sel_row;

    logic signed [OW-1:0]         left_reg, right_reg, row_reg;
    logic                         last_reg, cdone_reg;

    assign status.can_step = active_reg && (x_reg <= y_reg);
    assign status.fill     = fill_reg;

    // decision update for one octant step
    always_comb begin
        r_ext    = DW'(s_radius);
        dec_init = DW'(5) - (r_ext <<< 2);
        x_next   = x_reg + XW'(1);
        if (dec_reg > 0) begin
            y_next   = y_reg - XW'(1);
            dec_next = dec_reg - (DW'(y_next) <<< 3) + (DW'(x_next) <<< 3) + DW'(4);
        end else begin
            y_next   = y_reg;
            dec_next = dec_reg + (DW'(x_next) <<< 3) + DW'(4);
        end
        done_next = (x_next > y_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            fill_reg   <= 1'b0;
        end else if (cmd.load_start) begin
            active_reg <= 1'b1;
            fill_reg   <= s_fill_mode;
        end else if (cmd.take_step && done_next) begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_start) begin
            x_reg   <= '0;
            y_reg   <= XW'(s_radius);
            dec_reg <= dec_init;
            cx_reg  <= s_center_x;
            cy_reg  <= s_center_y;
        end else if (cmd.take_step) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            dec_reg  <= dec_next;
            ex_reg   <= x_reg;
            ey_reg   <= y_reg;
            done_reg <= done_next;
        end
    end

    // the eight symmetric coordinates, wrapped to the output width
    always_comb begin
        cxw   = WW'(cx_reg);
        cyw   = WW'(cy_reg);
        xw    = WW'(ex_reg);
        yw    = WW'(ey_reg);
        cx_px = cxw + xw;
        cx_mx = cxw - xw;
        cx_py = cxw + yw;
        cx_my = cxw - yw;
        cy_py = cyw + yw;
        cy_my = cyw - yw;
        cy_px = cyw + xw;
        cy_mx = cyw - xw;
    end

    always_comb begin
        sel_left  = cx_px[OW-1:0];
        sel_right = cx_px[OW-1:0];
        sel_row   = cy_py[OW-1:0];
        if (fill_reg) begin
            case (cmd.idx)
                3'd0: begin
                    sel_left  = cx_mx[OW-1:0];
                    sel_right = cx_px[OW-1:0];
                    sel_row   = cy_py[OW-1:0];
                end
                3'd1: begin
                    sel_left  = cx_mx[OW-1:0];
                    sel_right = cx_px[OW-1:0];
                    sel_row   = cy_my[OW-1:0];
                end
                3'd2: begin
                    sel_left  = cx_my[OW-1:0];
                    sel_right = cx_py[OW-1:0];
                    sel_row   = cy_px[OW-1:0];
                end
                default: begin
                    sel_left  = cx_my[OW-1:0];
                    sel_right = cx_py[OW-1:0];
                    sel_row   = cy_mx[OW-1:0];
                end
            endcase
        end else begin
            case (cmd.idx)
                3'd0: begin
                    sel_left = cx_px[OW-1:0];
                    sel_row  = cy_py[OW-1:0];
                end
                3'd1: begin
                    sel_left = cx_py[OW-1:0];
                    sel_row  = cy_px[OW-1:0];
                end
                3'd2: begin
                    sel_left = cx_mx[OW-1:0];
                    sel_row  = cy_py[OW-1:0];
                end
                3'd3: begin
                    sel_left = cx_my[OW-1:0];
                    sel_row  = cy_px[OW-1:0];
                end
                3'd4: begin
                    sel_left = cx_px[OW-1:0];
                    sel_row  = cy_my[OW-1:0];
                end
                3'd5: begin
                    sel_left = cx_py[OW-1:0];
                    sel_row  = cy_mx[OW-1:0];
                end
                3'd6: begin
                    sel_left = cx_mx[OW-1:0];
                    sel_row  = cy_my[OW-1:0];
                end
                default: begin
                    sel_left = cx_my[OW-1:0];
                    sel_row  = cy_mx[OW-1:0];
                end
            endcase
            sel_right = sel_left;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            left_reg  <= sel_left;
            right_reg <= sel_right;
            row_reg   <= sel_row;
            last_reg  <= cmd.last;
            cdone_reg <= done_reg;
        end
    end

    assign m_span_x_left  = left_reg;
    assign m_span_x_right = right_reg;
    assign m_span_row     = row_reg;
    assign m_last_of_step = last_reg;
    assign m_circle_done  = cdone_reg;

endmodule

`default_nettype wire

### src/midpoint_circle_rasterizer.sv
`default_nettype none

// Midpoint circle rasterizer. A start transaction (s_operation = 0) loads radius, centre and
// mode and produces no result; each advance transaction (s_operation = 1) runs one octant
// step and yields eight outline points or four horizontal spans, the final one flagged by
// m_last_of_step and all of the circle's last step flagged by m_circle_done. An advance
// with no circle running produces nothing. Once accepted, an advance yields one result per
// cycle while the sink is ready, through the single output register that the result
// sequencer loads; s_ready stays low until the step's final result is loaded. No
// clipping is done: coordinates wrap to 13 bits.
module midpoint_circle_rasterizer #(
    parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_operation,
    input  wire logic        [RADIUS_BITS-1:0]      s_radius,
    input  wire logic signed [COORD_BITS-1:0]       s_center_x,
    input  wire logic signed [COORD_BITS-1:0]       s_center_y,
    input  wire logic                               s_fill_mode,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [mcr_pkg::OUT_BITS-1:0]     m_span_x_left,
    output logic signed [mcr_pkg::OUT_BITS-1:0]     m_span_x_right,
    output logic signed [mcr_pkg::OUT_BITS-1:0]     m_span_row,
    output logic                                    m_last_of_step,
    output logic                                    m_circle_done
);

    mcr_pkg::ctrl_cmd_t  cmd;
    mcr_pkg::dp_status_t status;

    mcr_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    mcr_dp #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_radius       (s_radius),
        .s_center_x     (s_center_x),
        .s_center_y     (s_center_y),
        .s_fill_mode    (s_fill_mode),
        .cmd            (cmd),
        .status         (status),
        .m_span_x_left  (m_span_x_left),
        .m_span_x_right (m_span_x_right),
        .m_span_row     (m_span_row),
        .m_last_of_step (m_last_of_step),
        .m_circle_done  (m_circle_done)
    );

endmodule

`default_nettype wire

### src/mcr_checker.sv
`default_nettype none

module mcr_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              s_operation,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [mcr_pkg::OUT_BITS-1:0]      m_span_x_left,
    input wire logic [mcr_pkg::OUT_BITS-1:0]      m_span_row,
    input wire logic                              m_last_of_step
);

    // a stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_span_x_left) && $stable(m_span_row)))
        else $error("stalled result changed");

    // input side closes only after an accepted advance
    a_fell: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_operation))
        else $error("s_ready fell without an advance");

    // input side reopens only once the final result of a step is presented
    a_rose: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_ready) |-> (m_valid && m_last_of_step))
        else $error("s_ready rose before the step finished");

    // more results follow an accepted non-final result
    a_more: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_step) |=> m_valid)
        else $error("step ended without a final result");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_operation    (s_operation),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_span_x_left  (m_span_x_left),
    .m_span_row     (m_span_row),
    .m_last_of_step (m_last_of_step)
);

`default_nettype wire

### tb/sv/midpoint_circle_rasterizer_tb.sv
`default_nettype none

module midpoint_circle_rasterizer_tb;

    localparam int RB = mcr_pkg::RADIUS_BITS_DEF;
    localparam int CB = mcr_pkg::COORD_BITS_DEF;
    localparam int OB = mcr_pkg::OUT_BITS;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 450;

    typedef struct {
        logic signed [OB-1:0] left;
        logic signed [OB-1:0] right;
        logic signed [OB-1:0] row;
        logic                 last;
        logic                 done;
    } span_t;

    class circle_tracker;
        logic signed [RB:0]   step_x;
        logic signed [RB:0]   step_y;
        logic signed [RB+5:0] decision;
        logic signed [CB-1:0] held_cx;
        logic signed [CB-1:0] held_cy;
        logic                 held_fill;
        bit                   running;
        span_t                spans_due[$];
        int                   faults;

        function new();
            step_x    = '0;
            step_y    = '0;
            decision  = '0;
            held_cx   = '0;
            held_cy   = '0;
            held_fill = 1'b0;
            running   = 1'b0;
            faults    = 0;
        endfunction

        function int pending();
            return spans_due.size();
        endfunction

        function void fault(string msg);
            faults++;
            if (faults <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void add_span(ref span_t batch[$], input int left, input int right,
                               input int row);
            span_t s;
            s.left  = left[OB-1:0];
            s.right = right[OB-1:0];
            s.row   = row[OB-1:0];
            s.last  = 1'b0;
            s.done  = 1'b0;
            batch.push_back(s);
        endfunction

        // Returns 1 when the transaction changes the state or produces results.
        function bit take_command(mcr_pkg::op_t op, logic [RB-1:0] radius,
                                  logic signed [CB-1:0] cx, logic signed [CB-1:0] cy,
                                  logic fill);
            int    x, y, d, ccx, ccy;
            bit    finished;
            span_t batch[$];
            if (op == mcr_pkg::OP_START) begin
                held_cx   = cx;
                held_cy   = cy;
                held_fill = fill;
                step_x    = '0;
                step_y    = $signed({1'b0, radius});
                decision  = (RB+6)'(5 - 4 * int'(radius));
                running   = 1'b1;
                return 1'b1;
            end
            if (!running || step_x > step_y) begin
                return 1'b0;
            end
            x   = step_x;
            y   = step_y;
            d   = decision;
            ccx = held_cx;
            ccy = held_cy;
            if (held_fill) begin
                add_span(batch, ccx - x, ccx + x, ccy + y);
                add_span(batch, ccx - x, ccx + x, ccy - y);
                add_span(batch, ccx - y, ccx + y, ccy + x);
                add_span(batch, ccx - y, ccx + y, ccy - x);
            end else begin
                add_span(batch, ccx + x, ccx + x, ccy + y);
                add_span(batch, ccx + y, ccx + y, ccy + x);
                add_span(batch, ccx - x, ccx - x, ccy + y);
                add_span(batch, ccx - y, ccx - y, ccy + x);
                add_span(batch, ccx + x, ccx + x, ccy - y);
                add_span(batch, ccx + y, ccx + y, ccy - x);
                add_span(batch, ccx - x, ccx - x, ccy - y);
                add_span(batch, ccx - y, ccx - y, ccy - x);
            end
            if (d > 0) begin
                y = y - 1;
                d = d - 8 * y;
            end
            x = x + 1;
            d = d + 8 * x + 4;
            step_x   = (RB+1)'(x);
            step_y   = (RB+1)'(y);
            decision = (RB+6)'(d);
            finished = (x > y);
            if (finished) begin
                running = 1'b0;
            end
            batch[batch.size()-1].last = 1'b1;
            foreach (batch[k]) begin
                batch[k].done = finished;
                spans_due.push_back(batch[k]);
            end
            return 1'b1;
        endfunction

        function void check_span(logic signed [OB-1:0] left, logic signed [OB-1:0] right,
                                 logic signed [OB-1:0] row, logic last, logic done);
            span_t want;
            if (spans_due.size() == 0) begin
                fault($sformatf("unexpected result: left %0d right %0d row %0d last %b done %b",
                                left, right, row, last, done));
                return;
            end
            want = spans_due.pop_front();
            if (want.left !== left || want.right !== right || want.row !== row ||
                want.last !== last || want.done !== done) begin
                fault($sformatf({"mismatch: expected left %0d right %0d row %0d last %b done %b,",
                                 " got left %0d right %0d row %0d last %b done %b"},
                                want.left, want.right, want.row, want.last, want.done,
                                left, right, row, last, done));
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_operation;
    logic [RB-1:0]        s_radius;
    logic signed [CB-1:0] s_center_x;
    logic signed [CB-1:0] s_center_y;
    logic                 s_fill_mode;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [OB-1:0] m_span_x_left;
    logic signed [OB-1:0] m_span_x_right;
    logic signed [OB-1:0] m_span_row;
    logic                 m_last_of_step;
    logic                 m_circle_done;

    int            sender_gap_pct = 23;
    int            sink_stall_pct = 74;
    int            quiet_cycles   = 0;
    circle_tracker tracker;

    midpoint_circle_rasterizer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_radius       (s_radius),
        .s_center_x     (s_center_x),
        .s_center_y     (s_center_y),
        .s_fill_mode    (s_fill_mode),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_span_x_left  (m_span_x_left),
        .m_span_x_right (m_span_x_right),
        .m_span_row     (m_span_row),
        .m_last_of_step (m_last_of_step),
        .m_circle_done  (m_circle_done)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_span(m_span_x_left, m_span_x_right, m_span_row, m_last_of_step,
                               m_circle_done);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("midpoint_circle_rasterizer_tb: done, errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Present one transaction and hold it until accepted; valid stays high afterwards.
    task automatic send_item(mcr_pkg::op_t op, logic [RB-1:0] radius,
                             logic signed [CB-1:0] cx, logic signed [CB-1:0] cy,
                             logic fill, output bit useful);
        @(negedge aclk);
        while ($urandom_range(99) < sender_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_radius    <= radius;
        s_center_x  <= cx;
        s_center_y  <= cy;
        s_fill_mode <= fill;
        do @(posedge aclk); while (!s_ready);
        useful = tracker.take_command(op, radius, cx, cy, fill);
    endtask

    task automatic send_advance(output bit useful);
        send_item(mcr_pkg::OP_ADVANCE, RB'($urandom), CB'($urandom), CB'($urandom),
                  1'($urandom), useful);
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain_results();
        drop_valid();
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int            useful;
        int            phase;
        int            phase_now;
        int            cap;
        int            n;
        int            sel;
        bit            u;
        logic [RB-1:0] r;

        tracker = new();
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_operation <= mcr_pkg::OP_START;
        s_radius    <= '0;
        s_center_x  <= '0;
        s_center_y  <= '0;
        s_fill_mode <= 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // advance with no circle running
        send_advance(u);
        // zero radius, outline then fill; the advance after the end is ignored
        send_item(mcr_pkg::OP_START, '0, '0, '0, 1'b0, u);
        send_advance(u);
        send_advance(u);
        send_item(mcr_pkg::OP_START, '0, 12'sd2047, -12'sd2048, 1'b1, u);
        send_advance(u);
        // largest radius at opposite corners, abandoned by a fresh start
        send_item(mcr_pkg::OP_START, '1, 12'sd2047, 12'sd2047, 1'b0, u);
        send_advance(u);
        send_advance(u);
        send_item(mcr_pkg::OP_START, '1, -12'sd2048, -12'sd2048, 1'b1, u);
        send_advance(u);
        send_advance(u);
        send_item(mcr_pkg::OP_START, 10'd5, -12'sd1, 12'sd1, 1'b1, u);
        repeat (5) send_advance(u);
        send_item(mcr_pkg::OP_START, 10'd3, 12'sd100, -12'sd100, 1'b0, u);
        repeat (4) send_advance(u);
        drain_results();

        useful = 0;
        phase  = 0;
        while (useful < RANDOM_ITEMS) begin
            phase_now = useful / (RANDOM_ITEMS / 3);
            if (phase_now > 2) begin
                phase_now = 2;
            end
            if (phase_now != phase) begin
                phase = phase_now;
                drain_results();
                if (phase == 1) begin
                    sender_gap_pct = 74;
                    sink_stall_pct = 23;
                end else begin
                    sender_gap_pct = 0;
                    sink_stall_pct = 0;
                end
            end
            if ($urandom_range(99) < 80) begin
                sel = $urandom_range(99);
                if (sel < 85) begin
                    r = RB'($urandom_range(24, 0));
                end else if (sel < 95) begin
                    r = RB'($urandom_range(200, 25));
                end else begin
                    r = RB'($urandom);
                end
                // cut large circles short; now and then abandon a small one too
                cap = (r > 200 || $urandom_range(9) == 0) ? $urandom_range(6, 1) : 1 << 20;
                send_item(mcr_pkg::OP_START, r, CB'($urandom), CB'($urandom), 1'($urandom), u);
                useful += u;
                n = 0;
                while (tracker.running && n < cap) begin
                    send_advance(u);
                    useful += u;
                    n++;
                end
                repeat ($urandom_range(2)) begin
                    send_advance(u);
                    useful += u;
                end
            end else begin
                send_item(mcr_pkg::op_t'($urandom_range(1)), RB'($urandom), CB'($urandom),
                          CB'($urandom), 1'($urandom), u);
                useful += u;
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (tracker.faults == 0 && tracker.pending() == 0) begin
            $display("midpoint_circle_rasterizer_tb: done, clean");
        end else begin
            $display("midpoint_circle_rasterizer_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

### midpoint_circle_rasterizer.f
src/mcr_pkg.sv
src/mcr_ctrl.sv
src/mcr_dp.sv
src/midpoint_circle_rasterizer.sv
src/mcr_checker.sv
tb/sv/midpoint_circle_rasterizer_tb.sv
